[src/fbpa_pkg.sv]
`default_nettype none

package fbpa_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 17;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 4;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_INIT
  } state_t;

endpackage

`default_nettype wire

[src/fifo_block_pool_allocator_core.sv]
// Fixed-size block pool with a FIFO free list held in a 256 x 32 ring memory
// (one write port, one registered read port). Each command gives one result
// transfer: free, unknown commands and an alloc from an empty pool load the output
// register directly, a successful alloc passes the registered ring read first,
// and init writes one ring entry per cycle, n entries with n being block_count
// held to the range 1 to 256, before its result. A new command is taken once the
// previous result has left the output register or leaves it in the same cycle.
// After reset the pool holds no free blocks until an init command is issued.
`default_nettype none

module fifo_block_pool_allocator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]   in_release_address,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [fbpa_pkg::ADDR_W-1:0]        out_block_address,
  output logic [1:0]                         out_status,
  output logic [fbpa_pkg::CNT_W-1:0]         out_free_blocks,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fbpa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [fbpa_pkg::DATA_W-1:0]   pwdata,
  output logic [fbpa_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int AW = fbpa_pkg::ADDR_W;
  localparam int SW = fbpa_pkg::SIZE_W;
  localparam int IW = fbpa_pkg::IDX_W;
  localparam int CW = fbpa_pkg::CNT_W;
  localparam int DW = fbpa_pkg::DATA_W;

  fbpa_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] base_r;
  logic [SW-1:0] size_r;
  logic [CW-1:0] count_r;

  logic [IW-1:0] pop_r, pop_nxt;
  logic [IW-1:0] push_r, push_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic [IW-1:0] init_idx_r, init_idx_nxt;
  logic [AW-1:0] init_addr_r, init_addr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_addr_r, out_addr_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [CW-1:0] out_free_r, out_free_nxt;

  logic [AW-1:0] ring [fbpa_pkg::MAX_BLOCKS];
  logic [AW-1:0] ring_rdata_r;
  logic          ring_we;
  logic [IW-1:0] ring_waddr;
  logic [AW-1:0] ring_wdata;
  logic          ring_re;
  logic [IW-1:0] ring_raddr;

  logic [CW-1:0] n_eff;
  logic          in_xfer;
  logic          cfg_wr;

  function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] n);
    logic [CW-1:0] inc;
    inc = {{(CW-IW){1'b0}}, idx} + CW'(1);
    return (inc >= n) ? '0 : inc[IW-1:0];
  endfunction

  always_comb begin
    if (count_r == '0) begin
      n_eff = CW'(1);
    end else if (count_r > CW'(fbpa_pkg::MAX_BLOCKS)) begin
      n_eff = CW'(fbpa_pkg::MAX_BLOCKS);
    end else begin
      n_eff = count_r;
    end
  end

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign in_stall  = (state_r != fbpa_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign in_xfer   = in_valid && !in_stall;

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_status        = out_status_r;
  assign out_free_blocks   = out_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      size_r  <= SW'(64);
      count_r <= CW'(fbpa_pkg::MAX_BLOCKS);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fbpa_pkg::REG_BASE:  base_r  <= pwdata[AW-1:0];
        fbpa_pkg::REG_SIZE:  size_r  <= pwdata[SW-1:0];
        fbpa_pkg::REG_COUNT: count_r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fbpa_pkg::REG_BASE:  prdata = DW'(base_r);
      fbpa_pkg::REG_SIZE:  prdata = {{(DW-SW){1'b0}}, size_r};
      fbpa_pkg::REG_COUNT: prdata = {{(DW-CW){1'b0}}, count_r};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_waddr] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rdata_r <= ring[ring_raddr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pop_nxt        = pop_r;
    push_nxt       = push_r;
    free_nxt       = free_r;
    init_idx_nxt   = init_idx_r;
    init_addr_nxt  = init_addr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    ring_we        = 1'b0;
    ring_waddr     = push_r;
    ring_wdata     = in_release_address;
    ring_re        = 1'b0;
    ring_raddr     = pop_r;

    unique case (state_r)
      fbpa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_cmd)
            fbpa_pkg::CMD_ALLOC: begin
              if (free_r != '0) begin
                ring_re   = 1'b1;
                pop_nxt   = step_idx(pop_r, n_eff);
                free_nxt  = free_r - CW'(1);
                state_nxt = fbpa_pkg::ST_ALLOC;
              end else begin
                out_valid_nxt  = 1'b1;
                out_addr_nxt   = '0;
                out_status_nxt = fbpa_pkg::STS_EMPTY;
                out_free_nxt   = free_r;
              end
            end
            fbpa_pkg::CMD_FREE: begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              if (free_r >= n_eff) begin
                out_status_nxt = fbpa_pkg::STS_FULL;
                out_free_nxt   = free_r;
              end else begin
                ring_we        = 1'b1;
                push_nxt       = step_idx(push_r, n_eff);
                free_nxt       = free_r + CW'(1);
                out_status_nxt = fbpa_pkg::STS_OK;
                out_free_nxt   = free_r + CW'(1);
              end
            end
            fbpa_pkg::CMD_INIT: begin
              init_idx_nxt  = '0;
              init_addr_nxt = base_r;
              state_nxt     = fbpa_pkg::ST_INIT;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = '0;
              out_status_nxt = fbpa_pkg::STS_OK;
              out_free_nxt   = free_r;
            end
          endcase
        end
      end
      fbpa_pkg::ST_ALLOC: begin
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = ring_rdata_r;
        out_status_nxt = fbpa_pkg::STS_OK;
        out_free_nxt   = free_r;
        state_nxt      = fbpa_pkg::ST_IDLE;
      end
      fbpa_pkg::ST_INIT: begin
        ring_we       = 1'b1;
        ring_waddr    = init_idx_r;
        ring_wdata    = init_addr_r;
        init_addr_nxt = init_addr_r + {{(AW-SW){1'b0}}, size_r};
        init_idx_nxt  = init_idx_r + IW'(1);
        if (({{(CW-IW){1'b0}}, init_idx_r} + CW'(1)) >= n_eff) begin
          pop_nxt        = '0;
          push_nxt       = '0;
          free_nxt       = n_eff;
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = fbpa_pkg::STS_OK;
          out_free_nxt   = n_eff;
          state_nxt      = fbpa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fbpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbpa_pkg::ST_IDLE;
      pop_r       <= '0;
      push_r      <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pop_r       <= pop_nxt;
      push_r      <= push_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    init_idx_r   <= init_idx_nxt;
    init_addr_r  <= init_addr_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
  end

endmodule

`default_nettype wire
